// File: src/frec_pkg.sv
// ----------------------------------------------------------------------------
// frec_pkg: shared types and constants for the framed record envelope checker
// Header layout, status codes, envelope state record and the CRC-32 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package frec_pkg;

   localparam int unsigned HEADER_BYTES = 16;

   localparam logic [7:0] MAGIC_0 = 8'h50;  // 'P'
   localparam logic [7:0] MAGIC_1 = 8'h52;  // 'R'
   localparam logic [7:0] MAGIC_2 = 8'h53;  // 'S'
   localparam logic [7:0] MAGIC_3 = 8'h56;  // 'V'

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

   localparam int unsigned CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CURRENT_VERSION = 8'd0,
      REG_MAX_PAYLOAD     = 8'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_INVALID = 3'd2,
      ST_FUTURE  = 3'd3,
      ST_CORRUPT = 3'd4
   } status_type;

   // header byte positions
   typedef enum logic [3:0] {
      POS_MAGIC_0  = 4'd0,
      POS_MAGIC_1  = 4'd1,
      POS_MAGIC_2  = 4'd2,
      POS_MAGIC_3  = 4'd3,
      POS_VER_LO   = 4'd4,
      POS_VER_HI   = 4'd5,
      POS_HSIZE_LO = 4'd6,
      POS_HSIZE_HI = 4'd7,
      POS_LEN_0    = 4'd8,
      POS_LEN_1    = 4'd9,
      POS_LEN_2    = 4'd10,
      POS_LEN_3    = 4'd11,
      POS_CRC_0    = 4'd12,
      POS_CRC_1    = 4'd13,
      POS_CRC_2    = 4'd14,
      POS_CRC_3    = 4'd15
   } header_pos_type;

   typedef struct packed {
      logic [31:0] byte_count;
      logic        magic_ok;
      logic [15:0] version_word;
      logic [15:0] header_size_word;
      logic [31:0] length_word;
      logic [31:0] stored_crc_word;
      logic [31:0] crc_register;
   } envelope_type;

   typedef struct packed {
      logic [31:0] computed_crc;
      logic [31:0] payload_length;
      logic [15:0] stored_version;
      status_type  status;
   } result_type;

   localparam envelope_type ENVELOPE_CLEAR = '{
      byte_count:       32'd0,
      magic_ok:         1'b1,
      version_word:     16'd0,
      header_size_word: 16'd0,
      length_word:      32'd0,
      stored_crc_word:  32'd0,
      crc_register:     CRC_INIT
   };

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/frec_parser.sv
// ----------------------------------------------------------------------------
// frec_parser: envelope state tracker
// Captures header fields, checks magic, runs the payload CRC and counts bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module frec_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,        // byte enters the envelope
   input  wire logic               clear,       // envelope closes this cycle
   input  wire logic [7:0]         data_byte,
   output frec_pkg::envelope_type  env_now      // state including this byte
);

   frec_pkg::envelope_type env_ff;
   frec_pkg::envelope_type env_upd;
   frec_pkg::envelope_type env_in;
   logic                   in_header;

   assign in_header = (env_ff.byte_count[31:4] == 28'd0);

   always_comb begin
      env_upd = env_ff;
      if (in_header) begin
         case (frec_pkg::header_pos_type'(env_ff.byte_count[3:0]))
            frec_pkg::POS_MAGIC_0:  env_upd.magic_ok = env_ff.magic_ok &
                                                       (data_byte == frec_pkg::MAGIC_0);
            frec_pkg::POS_MAGIC_1:  env_upd.magic_ok = env_ff.magic_ok &
                                                       (data_byte == frec_pkg::MAGIC_1);
            frec_pkg::POS_MAGIC_2:  env_upd.magic_ok = env_ff.magic_ok &
                                                       (data_byte == frec_pkg::MAGIC_2);
            frec_pkg::POS_MAGIC_3:  env_upd.magic_ok = env_ff.magic_ok &
                                                       (data_byte == frec_pkg::MAGIC_3);
            frec_pkg::POS_VER_LO:   env_upd.version_word[7:0]      = data_byte;
            frec_pkg::POS_VER_HI:   env_upd.version_word[15:8]     = data_byte;
            frec_pkg::POS_HSIZE_LO: env_upd.header_size_word[7:0]  = data_byte;
            frec_pkg::POS_HSIZE_HI: env_upd.header_size_word[15:8] = data_byte;
            frec_pkg::POS_LEN_0:    env_upd.length_word[7:0]       = data_byte;
            frec_pkg::POS_LEN_1:    env_upd.length_word[15:8]      = data_byte;
            frec_pkg::POS_LEN_2:    env_upd.length_word[23:16]     = data_byte;
            frec_pkg::POS_LEN_3:    env_upd.length_word[31:24]     = data_byte;
            frec_pkg::POS_CRC_0:    env_upd.stored_crc_word[7:0]   = data_byte;
            frec_pkg::POS_CRC_1:    env_upd.stored_crc_word[15:8]  = data_byte;
            frec_pkg::POS_CRC_2:    env_upd.stored_crc_word[23:16] = data_byte;
            frec_pkg::POS_CRC_3:    env_upd.stored_crc_word[31:24] = data_byte;
            default:                env_upd = env_ff;
         endcase
      end else begin
         env_upd.crc_register = frec_pkg::crc_byte(env_ff.crc_register, data_byte);
      end
      if (env_ff.byte_count != frec_pkg::COUNT_MAX) begin
         env_upd.byte_count = env_ff.byte_count + 32'd1;
      end
   end

   assign env_now = take ? env_upd : env_ff;

   always_comb begin
      if (clear) begin
         env_in = frec_pkg::ENVELOPE_CLEAR;
      end else begin
         env_in = env_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= frec_pkg::ENVELOPE_CLEAR;
      end else begin
         env_ff <= env_in;
      end
   end

endmodule

`default_nettype wire

// File: src/frec_verdict.sv
// ----------------------------------------------------------------------------
// frec_verdict: envelope verdict
// Applies the checks in priority order to the closing envelope state.
// ----------------------------------------------------------------------------
`default_nettype none

module frec_verdict (
   input  wire frec_pkg::envelope_type env,
   input  wire logic [15:0]       current_version,
   input  wire logic [24:0]       max_payload_bytes,
   output frec_pkg::result_type   result
);

   logic [32:0] expected;
   logic [32:0] count_ext;
   logic [31:0] final_crc;

   assign expected  = 33'(frec_pkg::HEADER_BYTES) + {1'b0, env.length_word};
   assign count_ext = {1'b0, env.byte_count};
   assign final_crc = ~env.crc_register;

   always_comb begin
      if (env.byte_count == 32'd0) begin
         result.status = frec_pkg::ST_EMPTY;
      end else if (env.byte_count < 32'(frec_pkg::HEADER_BYTES)) begin
         result.status = frec_pkg::ST_INVALID;
      end else if (!env.magic_ok) begin
         result.status = frec_pkg::ST_INVALID;
      end else if (env.version_word > current_version) begin
         result.status = frec_pkg::ST_FUTURE;
      end else if (env.version_word == 16'd0 ||
                   env.header_size_word != 16'(frec_pkg::HEADER_BYTES)) begin
         result.status = frec_pkg::ST_INVALID;
      end else if (env.length_word == 32'd0) begin
         result.status = frec_pkg::ST_EMPTY;
      end else if (env.length_word > {7'd0, max_payload_bytes}) begin
         result.status = frec_pkg::ST_INVALID;
      end else if (count_ext < expected) begin
         result.status = frec_pkg::ST_CORRUPT;
      end else if (count_ext > expected) begin
         result.status = frec_pkg::ST_INVALID;
      end else if (final_crc != env.stored_crc_word) begin
         result.status = frec_pkg::ST_CORRUPT;
      end else begin
         result.status = frec_pkg::ST_OK;
      end
      result.stored_version = env.version_word;
      result.payload_length = env.length_word;
      result.computed_crc   = final_crc;
   end

endmodule

`default_nettype wire

// File: src/framed_record_envelope_checker.sv
// Path: a closing byte passes the s1 input register, then the verdict register.
// Throughput: one byte per cycle unless the input stalls; the CRC byte step and
// header capture are combinational. Input stalls only while a verdict waits in the
// output register and the registered byte also closes an envelope.
// Reset: synchronous, active high; clears both valid bits and the envelope state, and
// sets current_version to 1 and max_payload_bytes to 16777216.
// ----------------------------------------------------------------------------
// framed_record_envelope_checker: magic, length and CRC-32 envelope check
// Streams envelope bytes, parses the 16-byte header and gives one verdict
// per envelope on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_record_envelope_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] envelope_byte
   input  wire logic        req_tlast,    // is_last
   input  wire logic        req_tuser,    // [0] no_data
   // verdicts
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,    // [2:0] status, [18:3] stored_version,
                                          // [50:19] payload_length,
                                          // [82:51] computed_crc, [87:83] zero
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [24:0] csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_none_ff;
   logic        advance;
   logic        req_xfer;

   logic                 rsp_valid_ff, rsp_valid_in;
   frec_pkg::result_type rsp_data_ff;
   frec_pkg::result_type verdict;
   frec_pkg::envelope_type env_now;

   logic [15:0] current_version_ff;
   logic [24:0] max_payload_ff;

   // a closing byte may proceed only if the output register is free or draining
   assign advance    = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;
   assign s1_valid_in = req_xfer | (s1_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
         s1_none_ff <= req_tuser;
      end
   end

   frec_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (advance & ~s1_none_ff),
      .clear     (advance & s1_last_ff),
      .data_byte (s1_byte_ff),
      .env_now   (env_now)
   );

   frec_verdict u_verdict (
      .env               (env_now),
      .current_version   (current_version_ff),
      .max_payload_bytes (max_payload_ff),
      .result            (verdict)
   );

   assign rsp_valid_in = (advance & s1_last_ff) | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & s1_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // CSRs
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_version_ff <= 16'd1;
         max_payload_ff     <= 25'd16777216;
      end else if (csr_valid) begin
         case (frec_pkg::reg_index_type'(csr_index))
            frec_pkg::REG_CURRENT_VERSION: current_version_ff <= csr_data[15:0];
            frec_pkg::REG_MAX_PAYLOAD:     max_payload_ff     <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: src/frec_checker.sv
// ----------------------------------------------------------------------------
// frec_checker: port-level checks for the envelope checker
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module frec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata
);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict changed or dropped while stalled");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= frec_pkg::ST_CORRUPT)
      else $error("status code out of range");

   // an ok verdict needs a nonzero version and length
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == frec_pkg::ST_OK |-> rsp_tdata[18:3] != 16'd0 &&
                                                          rsp_tdata[50:19] != 32'd0)
      else $error("ok verdict with zero version or length");

   // with no verdict pending the input never stalls
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("verdict valid after reset");

endmodule

bind framed_record_envelope_checker frec_checker u_frec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/sv/envelope_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_verdict_checker: predicts and checks envelope verdicts
// Watches the byte stream, the verdict stream and the register port of the
// envelope checker, keeps its own copy of header capture, CRC-32 and the
// register values, and compares every verdict field by field in order.
// ----------------------------------------------------------------------------

module envelope_verdict_checker
   import frec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [24:0] csr_data,
   output int          fail_count,
   output int          open_count
);

   logic [15:0] cfg_top_version;
   logic [24:0] cfg_payload_cap;

   logic [31:0] env_count;
   logic        sig_good;
   logic [15:0] ver_field;
   logic [15:0] hdr_len_field;
   logic [31:0] len_field;
   logic [31:0] crc_field;
   logic [31:0] crc_acc;

   result_type  pending_verdicts [$];

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   task automatic clear_envelope();
      env_count     = '0;
      sig_good      = 1'b1;
      ver_field     = '0;
      hdr_len_field = '0;
      len_field     = '0;
      crc_field     = '0;
      crc_acc       = CRC_INIT;
   endtask

   // bit-serial reflected CRC, LSB of the byte first
   function automatic logic [31:0] crc_shift(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] b);
      if (env_count < HEADER_BYTES) begin
         case (header_pos_type'(env_count[3:0]))
            POS_MAGIC_0:  sig_good &= (b == MAGIC_0);
            POS_MAGIC_1:  sig_good &= (b == MAGIC_1);
            POS_MAGIC_2:  sig_good &= (b == MAGIC_2);
            POS_MAGIC_3:  sig_good &= (b == MAGIC_3);
            POS_VER_LO:   ver_field[7:0] = b;
            POS_VER_HI:   ver_field[15:8] = b;
            POS_HSIZE_LO: hdr_len_field[7:0] = b;
            POS_HSIZE_HI: hdr_len_field[15:8] = b;
            POS_LEN_0, POS_LEN_1, POS_LEN_2, POS_LEN_3:
               len_field[8*env_count[1:0] +: 8] = b;
            default:      crc_field[8*env_count[1:0] +: 8] = b;
         endcase
      end else begin
         crc_acc = crc_shift(crc_acc, b);
      end
      if (env_count != COUNT_MAX) env_count++;
   endtask

   function automatic status_type judge_envelope();
      logic [32:0] need;
      need = 33'(HEADER_BYTES) + {1'b0, len_field};
      if (env_count == 0) return ST_EMPTY;
      if (env_count < HEADER_BYTES) return ST_INVALID;
      if (!sig_good) return ST_INVALID;
      if (ver_field > cfg_top_version) return ST_FUTURE;
      if (ver_field == 0 || hdr_len_field != HEADER_BYTES) return ST_INVALID;
      if (len_field == 0) return ST_EMPTY;
      if (len_field > {7'd0, cfg_payload_cap}) return ST_INVALID;
      if ({1'b0, env_count} < need) return ST_CORRUPT;
      if ({1'b0, env_count} > need) return ST_INVALID;
      if (~crc_acc != crc_field) return ST_CORRUPT;
      return ST_OK;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         cfg_top_version = 16'd1;
         cfg_payload_cap = 25'd16777216;
         clear_envelope();
         pending_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CURRENT_VERSION: cfg_top_version = csr_data[15:0];
               REG_MAX_PAYLOAD:     cfg_payload_cap = csr_data;
               default: ;
            endcase
         end
         // check before queuing, so a verdict can never match its own transfer
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[82:0]);
            if (pending_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: verdict with none expected, actual 0x%0h", $time, rsp_tdata);
            end else begin
               want = pending_verdicts.pop_front();
               if (got.status != want.status)
                  note_mismatch("status", 32'(want.status), 32'(got.status));
               if (got.stored_version != want.stored_version)
                  note_mismatch("stored_version", 32'(want.stored_version),
                                32'(got.stored_version));
               if (got.payload_length != want.payload_length)
                  note_mismatch("payload_length", want.payload_length, got.payload_length);
               if (got.computed_crc != want.computed_crc)
                  note_mismatch("computed_crc", want.computed_crc, got.computed_crc);
               if (rsp_tdata[87:83] != '0)
                  note_mismatch("pad bits", 32'd0, 32'(rsp_tdata[87:83]));
            end
         end
         if (req_tvalid && req_tready) begin
            if (!req_tuser) absorb_byte(req_tdata);
            if (req_tlast) begin
               want.status         = judge_envelope();
               want.stored_version = ver_field;
               want.payload_length = len_field;
               want.computed_crc   = ~crc_acc;
               pending_verdicts.push_back(want);
               clear_envelope();
            end
         end
      end
      open_count <= pending_verdicts.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus for the framed record envelope checker
// Streams directed and random envelopes (half of the random ones well formed, the rest with
// each header or length fault, short headers, empties and noise) through
// several register settings and idle patterns; the checker module judges.
// ----------------------------------------------------------------------------

module tb_top;
   import frec_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int PHASES      = 8;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {
      ENV_GOOD,
      ENV_BAD_CRC,
      ENV_SHORT_PAYLOAD,
      ENV_LONG_PAYLOAD,
      ENV_BAD_MAGIC,
      ENV_FUTURE,
      ENV_ZERO_VERSION,
      ENV_BAD_HSIZE,
      ENV_ZERO_LENGTH,
      ENV_OVERSIZE,
      ENV_SHORT_HEADER,
      ENV_EMPTY,
      ENV_NOISE
   } envelope_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [7:0]  csr_index  = '0;
   logic [24:0] csr_data   = '0;

   wire         req_tready;
   wire         rsp_tvalid;
   wire [87:0]  rsp_tdata;
   wire         csr_ready;

   int          fail_count;
   int          open_count;
   int          tx_idle_pct  = 0;
   int          rx_stall_pct = 0;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   int          directed_items;

   logic [15:0] top_version = 16'd1;
   logic [24:0] payload_cap = 25'd16777216;
   logic [7:0]  env_bytes [$];

   always #5 clock = ~clock;

   framed_record_envelope_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   envelope_verdict_checker verdict_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last, input logic none);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= none;
      do @(posedge clock); while (!req_tready);
      if (last || !none) items_sent++;
   endtask

   function automatic int unsigned pick_len();
      int unsigned hi;
      hi = ($urandom_range(0, 19) == 0) ? 160 : 10;
      if (hi > payload_cap) hi = payload_cap;
      return $urandom_range(1, hi);
   endfunction

   function automatic envelope_kind_type pick_kind();
      if ($urandom_range(0, 99) < 50) return ENV_GOOD;
      return envelope_kind_type'($urandom_range(ENV_BAD_CRC, ENV_NOISE));
   endfunction

   task automatic push_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++) env_bytes.push_back(value[8*i +: 8]);
   endtask

   // fills env_bytes; force_len of zero picks a random payload length
   task automatic build_envelope(input envelope_kind_type kind, input int unsigned force_len);
      logic [7:0]  sig [4];
      logic [7:0]  body [$];
      logic [15:0] ver;
      logic [15:0] hsize;
      logic [31:0] len;
      logic [31:0] crc;
      int unsigned body_n;
      int unsigned cut;
      int unsigned pos;
      sig   = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
      ver   = 16'($urandom_range(1, top_version));
      hsize = 16'(HEADER_BYTES);
      len   = (force_len != 0) ? force_len : pick_len();
      body_n = len;
      case (kind)
         ENV_BAD_MAGIC: begin
            pos = $urandom_range(0, 3);
            sig[pos] ^= 8'($urandom_range(1, 255));
         end
         ENV_FUTURE:
            ver = (top_version == 16'hFFFF) ? 16'd0
                                            : 16'($urandom_range(top_version + 1, 65535));
         ENV_ZERO_VERSION: ver = '0;
         ENV_BAD_HSIZE: begin
            hsize = 16'($urandom_range(0, 65535));
            if (hsize == HEADER_BYTES) hsize = 16'(HEADER_BYTES + 1);
         end
         ENV_ZERO_LENGTH: begin
            len    = '0;
            body_n = $urandom_range(0, 3);
         end
         ENV_OVERSIZE: begin
            len = {7'd0, payload_cap} + 32'd1;
            if ($urandom_range(0, 3) != 0) len = $urandom_range(len, 32'hFFFFFFFF);
            body_n = $urandom_range(0, 6);
         end
         ENV_SHORT_PAYLOAD: body_n = $urandom_range(0, len - 1);
         ENV_LONG_PAYLOAD:  body_n = len + $urandom_range(1, 4);
         default: ;
      endcase
      crc = CRC_INIT;
      for (int i = 0; i < body_n; i++) begin
         body.push_back(8'($urandom));
         crc = crc_byte(crc, body[i]);
      end
      crc = ~crc;
      if (kind == ENV_BAD_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
      env_bytes.delete();
      foreach (sig[i]) env_bytes.push_back(sig[i]);
      push_le(32'(ver), 2);
      push_le(32'(hsize), 2);
      push_le(len, 4);
      push_le(crc, 4);
      foreach (body[i]) env_bytes.push_back(body[i]);
      case (kind)
         ENV_SHORT_HEADER: begin
            cut = $urandom_range(1, HEADER_BYTES - 1);
            while (env_bytes.size() > cut) void'(env_bytes.pop_back());
         end
         ENV_EMPTY: env_bytes.delete();
         ENV_NOISE: begin
            env_bytes.delete();
            cut = $urandom_range(1, 40);
            repeat (cut) env_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
   endtask

   // junk_pct: chance of a dataless, non-closing item before each byte
   task automatic send_envelope(input int unsigned junk_pct);
      int unsigned n;
      logic        close_dataless;
      n = env_bytes.size();
      close_dataless = (n == 0) || ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < junk_pct) send_item(8'($urandom), 1'b0, 1'b1);
         send_item(env_bytes[i], !close_dataless && (i == n - 1), 1'b0);
      end
      if (close_dataless) send_item(8'($urandom), 1'b1, 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] ver, input logic [24:0] cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= REG_CURRENT_VERSION;
      csr_data  <= {9'd0, ver};
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_MAX_PAYLOAD;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      top_version = ver;
      payload_cap = cap;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored item, empty envelope, short header, minimal good frame
      send_item(8'hA5, 1'b0, 1'b1);
      build_envelope(ENV_EMPTY, 0);
      send_envelope(0);
      build_envelope(ENV_SHORT_HEADER, 0);
      send_envelope(0);
      build_envelope(ENV_GOOD, 1);
      send_envelope(0);
      directed_items = items_sent;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_registers(16'hFFFF, 25'd1);
            1: set_registers(16'd1, 25'd16777216);
            2: set_registers(16'($urandom_range(2, 400)), 25'($urandom_range(2, 64)));
            3: set_registers(16'($urandom_range(1, 65535)),
                             25'($urandom_range(1, 16777216)));
            4: set_registers(16'd1, 25'd1);
            5: set_registers(16'hFFFF, 25'd16777216);
            6: set_registers(16'($urandom_range(1, 20)), 25'($urandom_range(10, 300)));
            default: set_registers(16'($urandom_range(1, 65535)),
                                   25'($urandom_range(1, 40)));
         endcase
         case (phase % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
            default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
         endcase
         while (items_sent < directed_items + ITEM_TARGET * (phase + 1) / PHASES) begin
            build_envelope(pick_kind(), 0);
            send_envelope(4);
         end
      end

      wait_drained();
      if (fail_count == 0 && open_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
